/* hw/rtl/lpfs_pkg.sv */
// Package for the longest previous factor stack: beat types and fixed constants.
// Used by the front end, the stack engine and the top level; depends on nothing.
package lpfs_pkg;

   // Field widths fixed by the item formats.
   localparam int POS_W = 6;
   localparam int LEN_W = 6;

   // At most this many results leave the block for one input item.
   localparam int RESULT_CAP = 64;
   localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

   // One input beat.
   typedef struct packed {
      logic [POS_W-1:0] suffix_pos;
      logic [LEN_W-1:0] common_prefix;
      logic             last_entry;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [POS_W-1:0] text_pos;
      logic [LEN_W-1:0] factor_length;
      logic [POS_W-1:0] prev_pos;
      logic             has_prev;
      logic             stack_overflowed;
      logic             last_result;
   } rsp_type;

   // Classified item handed from the front to the stack engine.
   typedef struct packed {
      req_type item;
      logic    first;
   } cmd_type;

   // One stack entry: carried common length and text position.
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [POS_W-1:0] pos;
   } pair_type;

endpackage

/* hw/rtl/lpfs_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; no package needed.
module lpfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lpfs_queue.sv */
// Small first-in first-out queue built from registers, with push/full and pop/empty.
// Self-contained; used for the command queue and the result queue.
module lpfs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == FW'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Pointer advance with wrap at the queue depth, and fill tracking.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/lpfs_front.sv */
// Front end: accepts input beats, marks the first entry of each sequence, queues commands.
// Depends on lpfs_pkg and lpfs_queue.
module lpfs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  lpfs_pkg::req_type req_data,
   output logic              cmd_empty,
   input  logic              cmd_pop,
   output lpfs_pkg::cmd_type cmd_data
);

   import lpfs_pkg::*;

   logic                   seq_open_ff, seq_open_in;
   logic                   accept;
   cmd_type                cmd_new;
   logic [$bits(cmd_type)-1:0] cmd_vec;

   assign accept = req_push && !req_full;

   // A sequence opens with any entry and closes with the entry marked last.
   always_comb begin
      seq_open_in = seq_open_ff;
      if (accept) begin
         seq_open_in = !req_data.last_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_open_ff <= 1'b0;
      end else begin
         seq_open_ff <= seq_open_in;
      end
   end

   // The entry that opens a sequence ignores its common prefix.
   always_comb begin
      cmd_new.item  = req_data;
      cmd_new.first = !seq_open_ff;
   end

   lpfs_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_new),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_vec),
      .empty     (cmd_empty)
   );

   assign cmd_data = cmd_type'(cmd_vec);

endmodule

/* hw/rtl/lpfs_back.sv */
// Back end: the stack engine that pushes entries, pops larger-position entries and emits results.
// Depends on lpfs_pkg and lpfs_ram.
module lpfs_back #(
   parameter int MAX_LENGTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  lpfs_pkg::cmd_type cmd_data,
   input  logic              res_full,
   output logic              res_push,
   output lpfs_pkg::rsp_type res_data
);

   import lpfs_pkg::*;

   localparam int AW = $clog2(MAX_LENGTH);
   localparam int CW = $clog2(MAX_LENGTH + 1);

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   pair_type               top_ff, top_in;
   logic [LEN_W-1:0]       u_ff, u_in;
   logic                   mid_ff, mid_in;
   logic [RES_CNT_W-1:0]   n_ff, n_in;
   logic                   ovf_ff, ovf_in;

   pair_type               below;
   pair_type               push_pair;
   logic [$bits(pair_type)-1:0] ram_rd;
   logic                   ram_we;
   logic [CW-1:0]          rd_count;
   logic [AW-1:0]          rd_addr;

   logic [LEN_W-1:0]       u_eff, lpf, u_min;
   logic [POS_W-1:0]       new_pos;
   logic [CW-1:0]          count_dec;
   logic                   stack_nz, below_ok, emit_ok, last_step;
   logic                   want_pop, pop_fire, push_fire;

   // The RAM always reads the entry just under the top of the next stack.
   lpfs_ram #(
      .WIDTH ($bits(pair_type)),
      .DEPTH (MAX_LENGTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (push_pair),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign below    = pair_type'(ram_rd);
   assign rd_count = count_in - CW'(2);
   assign rd_addr  = rd_count[AW-1:0];

   // Operand selection: a new item starts with its own common prefix.
   assign u_eff     = (state_ff == ST_RUN && !mid_ff) ? cmd_data.item.common_prefix : u_ff;
   assign new_pos   = (state_ff == ST_FLUSH) ? '0 : cmd_data.item.suffix_pos;
   assign stack_nz  = (count_ff != '0);
   assign count_dec = count_ff - CW'(1);
   assign below_ok  = (count_dec != '0);
   assign emit_ok   = (n_ff < RES_CNT_W'(RESULT_CAP));
   assign last_step = (state_ff == ST_FLUSH) || cmd_data.item.last_entry;
   assign lpf       = (top_ff.len > u_eff) ? top_ff.len : u_eff;
   assign u_min     = (top_ff.len < u_eff) ? top_ff.len : u_eff;

   // Decide between popping the top and pushing the current entry.
   always_comb begin
      want_pop  = 1'b0;
      push_fire = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (!cmd_empty) begin
               want_pop  = !cmd_data.first && stack_nz &&
                           (cmd_data.item.suffix_pos < top_ff.pos);
               push_fire = !want_pop;
            end
         end
         ST_FLUSH: begin
            want_pop = stack_nz;
         end
         default: begin
            want_pop  = 1'b0;
            push_fire = 1'b0;
         end
      endcase
   end

   // A pop that produces a beat waits for room; a discarded one does not.
   assign pop_fire = want_pop && (!emit_ok || !res_full);
   assign res_push = pop_fire && emit_ok;
   assign cmd_pop  = push_fire;

   always_comb begin
      push_pair.len = cmd_data.first ? '0 : u_eff;
      push_pair.pos = cmd_data.item.suffix_pos;
   end

   // Result of popping the top pair.
   always_comb begin
      res_data.text_pos         = top_ff.pos;
      res_data.factor_length    = lpf;
      res_data.prev_pos         = '0;
      res_data.has_prev         = 1'b0;
      res_data.stack_overflowed = ovf_ff;
      res_data.last_result      = last_step &&
                                  ((n_ff == RES_CNT_W'(RESULT_CAP - 1)) ||
                                   (state_ff == ST_FLUSH && !below_ok));
      if (lpf != '0) begin
         if (top_ff.len > u_min) begin
            if (below_ok) begin
               res_data.prev_pos = below.pos;
               res_data.has_prev = 1'b1;
            end
         end else begin
            res_data.prev_pos = new_pos;
            res_data.has_prev = 1'b1;
         end
      end
   end

   // Stack and sequence state update.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      top_in   = top_ff;
      u_in     = u_ff;
      mid_in   = mid_ff;
      n_in     = n_ff;
      ovf_in   = ovf_ff;
      ram_we   = 1'b0;
      if (pop_fire) begin
         count_in = count_dec;
         top_in   = below;
         u_in     = u_min;
         if (emit_ok) begin
            n_in = n_ff + RES_CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (state_ff == ST_RUN) begin
            mid_in = 1'b1;
         end else if (!below_ok) begin
            state_in = ST_RUN;
            n_in     = '0;
         end
      end else if (push_fire) begin
         mid_in = 1'b0;
         if (count_ff == CW'(MAX_LENGTH)) begin
            ovf_in = 1'b1;
         end else begin
            ram_we   = 1'b1;
            top_in   = push_pair;
            count_in = count_ff + CW'(1);
         end
         if (cmd_data.item.last_entry) begin
            state_in = ST_FLUSH;
            u_in     = '0;
         end else begin
            n_in = '0;
         end
      end else if (state_ff == ST_FLUSH && !stack_nz) begin
         state_in = ST_RUN;
         n_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         count_ff <= '0;
         mid_ff   <= 1'b0;
         n_ff     <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mid_ff   <= mid_in;
         n_ff     <= n_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Cached top pair and carried length need no reset.
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      u_ff   <= u_in;
   end

`ifndef NO_ASSERTIONS
   // The stack never holds more pairs than the RAM has rows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LENGTH))
      else $error("stack count above depth");

   // A result beat is only offered when the result queue has room.
   a_res_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result beat pushed into full queue");

   // During the flush no command is consumed.
   a_flush_no_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> !cmd_pop)
      else $error("command consumed during flush");

   // Each pop removes exactly one pair.
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (pop_fire && !reset) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("pop did not remove one pair");

   // The per-item result count never passes the cap.
   a_res_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RES_CNT_W'(RESULT_CAP))
      else $error("result count above cap");
`endif

endmodule

/* hw/rtl/longest_previous_factor_stack.sv */
// Top level of the longest previous factor stack: front end, stack engine, result queue.
// Depends on lpfs_pkg, lpfs_front, lpfs_back and lpfs_queue.
//
// Suffix-array entries enter in rank order, each with its common prefix length, and the
// block returns one result beat per stack pop, up to RESULT_CAP per item: the text
// position, its longest previous factor length and the earlier occurrence, if any. An entry
// marked last also empties the stack, and the final beat of that flush carries last_result.
// The stack engine does one stack operation per cycle, unless it waits for a command or for
// room in the result queue, through a single RAM write port and one read port: an item
// takes one push plus one pop for each pair it removes. A two-beat command queue and a
// two-beat result queue let input and output stall independently. If a push finds the
// stack full, the entry is dropped and the sticky stack_overflowed flag is set until reset.
module longest_previous_factor_stack #(
   parameter int MAX_LENGTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  lpfs_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output lpfs_pkg::rsp_type rsp_data
);

   import lpfs_pkg::*;

   logic                       cmd_empty, cmd_pop;
   cmd_type                    cmd_data;
   logic                       res_full, res_push;
   rsp_type                    res_data;
   logic [$bits(rsp_type)-1:0] rsp_vec;

   // Accept and classify input beats.
   lpfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   // Stack engine.
   lpfs_back #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   // Result queue toward the consumer.
   lpfs_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_vec),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_vec);

endmodule
